// File: hw/rtl/lswmc_pkg.sv
`timescale 1ns / 1ps

package lswmc_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 2;
    localparam logic [15:0] LEVEL_NEVER = 16'hffff;
    localparam int DIV_STEPS = 32;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_ONESHOT = 2'd1,
        MODE_FREERUN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } side_t;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic CFG_LEFT_PIN  = 1'b0;
    localparam logic CFG_RIGHT_PIN = 1'b1;

    typedef struct packed {
        logic        op;
        logic [1:0]  new_mode;
        logic [15:0] window_length;
        logic [5:0]  source_pin;
        logic [15:0] sample_value;
        logic [31:0] time_now;
    } in_t;

    typedef struct packed {
        logic [15:0] left_threshold;
        logic [15:0] right_threshold;
        logic        calibrating;
        logic        window_closed;
    } out_t;

    // Classified command handed from the front to the back through the queue
    typedef struct packed {
        logic        is_restart;
        mode_t       mode;
        logic [15:0] wlen;
        side_t       side;
        logic [15:0] value;
        logic [31:0] time_now;
    } cmd_t;

endpackage

// File: hw/rtl/lswmc_fifo.sv
`timescale 1ns / 1ps

module lswmc_fifo
    import lswmc_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/lswmc_front.sv
`timescale 1ns / 1ps

module lswmc_front
    import lswmc_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    input  logic [5:0] left_pin,
    input  logic [5:0] right_pin,
    input  logic       queue_full,
    output logic       push,
    output cmd_t       cmd
);

    mode_t mode_norm;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Fold the unused mode code into free-running
    always_comb
    begin
        unique case (in_data.new_mode)
            MODE_STOPPED: mode_norm = MODE_STOPPED;
            MODE_ONESHOT: mode_norm = MODE_ONESHOT;
            default:      mode_norm = MODE_FREERUN;
        endcase
    end

    always_comb
    begin
        cmd.is_restart = (in_data.op == OP_RESTART);
        cmd.mode       = mode_norm;
        // A stopped restart carries a zero window
        cmd.wlen       = (mode_norm == MODE_STOPPED) ? 16'd0 : in_data.window_length;
        cmd.value      = in_data.sample_value;
        cmd.time_now   = in_data.time_now;
        // Left wins when both pins match
        if (in_data.source_pin == left_pin)
        begin
            cmd.side = SIDE_LEFT;
        end
        else if (in_data.source_pin == right_pin)
        begin
            cmd.side = SIDE_RIGHT;
        end
        else
        begin
            cmd.side = SIDE_NONE;
        end
    end

endmodule

// File: hw/rtl/lswmc_div.sv
`timescale 1ns / 1ps

module lswmc_div
    import lswmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [15:0] quotient
);

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic [31:0]       rem_reg;
    logic [31:0]       quo_reg;
    logic [31:0]       divisor_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [32:0]       shifted;
    logic [32:0]       diff;

    // Restoring division, one quotient bit per cycle while busy
    assign shifted  = {rem_reg, quo_reg[31]};
    assign diff     = shifted - {1'b0, divisor_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg[15:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[32] ? shifted[31:0] : diff[31:0];
            quo_reg <= {quo_reg[30:0], ~diff[32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/lswmc_back.sv
`timescale 1ns / 1ps

module lswmc_back
    import lswmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic queue_empty,
    output logic pop,
    input  cmd_t cmd,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    cmd_t        cur_reg;
    mode_t       mode_reg;
    logic [15:0] window_size_reg;
    logic [31:0] window_end_reg;
    logic [31:0] left_sum_reg;
    logic [31:0] left_count_reg;
    logic [31:0] right_sum_reg;
    logic [31:0] right_count_reg;
    logic [15:0] left_level_reg;
    logic [15:0] right_level_reg;
    logic        closed_reg;
    logic        left_upd_reg;
    logic        right_upd_reg;
    logic        out_valid_reg;
    out_t        out_data_reg;

    logic        active_sample;
    logic        closing;
    logic        keep_running;
    logic        add_left;
    logic        add_right;
    logic [31:0] left_sum_base;
    logic [31:0] left_count_base;
    logic [31:0] right_sum_base;
    logic [31:0] right_count_base;
    logic [31:0] value_ext;
    logic        div_start;
    logic        left_busy;
    logic        right_busy;
    logic [15:0] left_quo;
    logic [15:0] right_quo;
    logic        out_free;

    assign active_sample = !cur_reg.is_restart && (mode_reg != MODE_STOPPED);
    assign closing       = active_sample && (cur_reg.time_now >= window_end_reg);
    assign keep_running  = !closing || (mode_reg == MODE_FREERUN);
    assign add_left      = active_sample && keep_running && (cur_reg.side == SIDE_LEFT);
    assign add_right     = active_sample && keep_running && (cur_reg.side == SIDE_RIGHT);
    assign left_sum_base    = closing ? '0 : left_sum_reg;
    assign left_count_base  = closing ? '0 : left_count_reg;
    assign right_sum_base   = closing ? '0 : right_sum_reg;
    assign right_count_base = closing ? '0 : right_count_reg;
    assign value_ext     = {16'd0, cur_reg.value};
    assign div_start     = (state_reg == ST_EXEC) && closing;
    assign out_free      = !out_valid_reg || !out_stall;
    assign pop           = (state_reg == ST_IDLE) && !queue_empty;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    lswmc_div u_div_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left_sum_reg),
        .divisor  (left_count_reg),
        .busy     (left_busy),
        .quotient (left_quo)
    );

    lswmc_div u_div_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (right_sum_reg),
        .divisor  (right_count_reg),
        .busy     (right_busy),
        .quotient (right_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = closing ? ST_DIVIDE : ST_EMIT;
            end
            ST_DIVIDE:
            begin
                if (!left_busy && !right_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= cmd;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_data_reg.left_threshold  <= left_level_reg;
            out_data_reg.right_threshold <= right_level_reg;
            out_data_reg.calibrating     <= (mode_reg != MODE_STOPPED);
            out_data_reg.window_closed   <= closed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_STOPPED;
            window_size_reg <= '0;
            window_end_reg  <= '0;
            left_sum_reg    <= '0;
            left_count_reg  <= '0;
            right_sum_reg   <= '0;
            right_count_reg <= '0;
            left_level_reg  <= LEVEL_NEVER;
            right_level_reg <= LEVEL_NEVER;
            closed_reg      <= 1'b0;
            left_upd_reg    <= 1'b0;
            right_upd_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_EXEC)
            begin
                if (cur_reg.is_restart)
                begin
                    mode_reg        <= cur_reg.mode;
                    window_size_reg <= cur_reg.wlen;
                    window_end_reg  <= cur_reg.time_now + {16'd0, cur_reg.wlen};
                    left_sum_reg    <= '0;
                    left_count_reg  <= '0;
                    right_sum_reg   <= '0;
                    right_count_reg <= '0;
                    closed_reg      <= 1'b0;
                end
                else
                begin
                    // Clear on close, then fold in the sample if still running
                    left_sum_reg    <= left_sum_base + (add_left ? value_ext : 32'd0);
                    left_count_reg  <= left_count_base + {31'd0, add_left};
                    right_sum_reg   <= right_sum_base + (add_right ? value_ext : 32'd0);
                    right_count_reg <= right_count_base + {31'd0, add_right};
                    closed_reg      <= closing;
                    if (closing)
                    begin
                        left_upd_reg  <= (left_count_reg != '0);
                        right_upd_reg <= (right_count_reg != '0);
                        if (mode_reg == MODE_ONESHOT)
                        begin
                            mode_reg <= MODE_STOPPED;
                        end
                        else
                        begin
                            window_end_reg <= window_end_reg + {16'd0, window_size_reg};
                        end
                    end
                end
            end

            if ((state_reg == ST_DIVIDE) && !left_busy && !right_busy)
            begin
                if (left_upd_reg)
                begin
                    left_level_reg <= left_quo;
                end
                if (right_upd_reg)
                begin
                    right_level_reg <= right_quo;
                end
            end

            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/light_sensor_window_mean_calibrator_core.sv
// Light sensor window-mean calibrator. Each input transfer is either a restart
// (mode, window length, timestamp) or an analog sample (pin, value, timestamp);
// each one yields exactly one output transfer carrying both thresholds, the
// calibrating flag and whether this item closed a window. At a window close
// each side with samples takes the truncated mean (sum / count, low 16 bits)
// as its threshold. A front stage classifies items (mode folding, pin match
// against the left_pin and right_pin registers) into a short command queue;
// a back stage executes them one at a time and owns the output register.
// An ordinary item passes the EXEC and EMIT states of the back stage; an item
// that closes a window also waits in DIVIDE for the two 32-step restoring
// dividers, which run in parallel, one per side. The queue takes up to
// QUEUE_DEPTH transfers while the back stage works or the output waits; once
// it is full the input stalls. Configuration writes are only valid while idle.
`timescale 1ns / 1ps

module light_sensor_window_mean_calibrator_core
    import lswmc_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data
);

    logic [5:0] left_pin_reg;
    logic [5:0] right_pin_reg;
    logic       queue_full;
    logic       queue_empty;
    logic       push;
    logic       pop;
    cmd_t       push_cmd;
    cmd_t       pop_cmd;

    // Pin registers: plain writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pin_reg  <= 6'd0;
            right_pin_reg <= 6'd1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_LEFT_PIN:  left_pin_reg  <= cfg_data;
                CFG_RIGHT_PIN: right_pin_reg <= cfg_data;
                default:       left_pin_reg  <= left_pin_reg;
            endcase
        end
    end

    // Front: classify each transfer and push it into the queue
    lswmc_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .left_pin   (left_pin_reg),
        .right_pin  (right_pin_reg),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Hold classified commands between front and back
    lswmc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (queue_empty)
    );

    // Back: update statistics, divide at window close, drive the result
    lswmc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop         (pop),
        .cmd         (pop_cmd),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// File: test/light_sensor_window_mean_calibrator_core_tb.sv
`timescale 1ns / 1ps

module light_sensor_window_mean_calibrator_core_tb;
    import lswmc_pkg::*;

    // Restart mode code with no enum member; the block folds it to free-running
    localparam logic [1:0] MODE_CODE_SPARE = 2'd3;

    // One directed step: either a pin register write or an input transfer,
    // optionally with the output spelled out by hand
    typedef struct packed {
        bit         is_cfg;
        logic       cfg_sel;
        logic [5:0] cfg_pin;
        in_t        item;
        bit         typed;
        out_t       want;
    } step_row_t;

    localparam int PLAN_ROWS = 23;

    localparam step_row_t PLAN [0:PLAN_ROWS-1] = '{
        // Sample right after reset: block is stopped, nothing moves
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd0, 16'h1234, 32'd0},
          1'b1, '{16'hffff, 16'hffff, 1'b0, 1'b0}},
        // Stopped restart squashes the window length
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_RESTART, MODE_STOPPED, 16'd100, 6'd0, 16'd0, 32'd5},
          1'b1, '{16'hffff, 16'hffff, 1'b0, 1'b0}},
        // One-shot window ending at 1100
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_RESTART, MODE_ONESHOT, 16'd100, 6'd0, 16'd0, 32'd1000},
          1'b1, '{16'hffff, 16'hffff, 1'b1, 1'b0}},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd0, 16'hffff, 32'd1010},
          1'b0, '0},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd0, 16'h0001, 32'd1020},
          1'b0, '0},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd1, 16'h0000, 32'd1030},
          1'b0, '0},
        // Pin matching neither side
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd5, 16'habcd, 32'd1040},
          1'b0, '0},
        // Close exactly at the window end: left mean 0x8000, right mean 0, one-shot stops
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd1, 16'd300, 32'd1100},
          1'b1, '{16'h8000, 16'h0000, 1'b0, 1'b1}},
        // Sample after the one-shot stopped
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd0, 16'd5, 32'd2000},
          1'b1, '{16'h8000, 16'h0000, 1'b0, 1'b0}},
        // Spare mode code, longest window, end wraps past zero
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_RESTART, MODE_CODE_SPARE, 16'hffff, 6'd0, 16'd0, 32'hffff_ff00},
          1'b1, '{16'h8000, 16'h0000, 1'b1, 1'b0}},
        // Wrapped end compares unsigned, so this closes an empty window
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd0, 16'd7, 32'hffff_ff10},
          1'b1, '{16'h8000, 16'h0000, 1'b1, 1'b1}},
        // Zero-length free-running window at the top of the timer
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_RESTART, MODE_FREERUN, 16'd0, 6'd0, 16'd0, 32'hffff_ffff},
          1'b1, '{16'h8000, 16'h0000, 1'b1, 1'b0}},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd1, 16'hffff, 32'hffff_ffff},
          1'b1, '{16'h8000, 16'h0000, 1'b1, 1'b1}},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd1, 16'h0010, 32'hffff_ffff},
          1'b0, '0},
        // Both sensors on the same pin: left side wins
        '{1'b1, CFG_LEFT_PIN, 6'd63, '0, 1'b0, '0},
        '{1'b1, CFG_RIGHT_PIN, 6'd63, '0, 1'b0, '0},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_RESTART, MODE_ONESHOT, 16'd10, 6'd0, 16'd0, 32'd0},
          1'b0, '0},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd63, 16'h8000, 32'd1},
          1'b0, '0},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd63, 16'h0000, 32'd10},
          1'b0, '0},
        '{1'b1, CFG_RIGHT_PIN, 6'd0, '0, 1'b0, '0},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_RESTART, MODE_FREERUN, 16'd3, 6'd0, 16'd0, 32'd20},
          1'b0, '0},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd0, 16'hffff, 32'd21},
          1'b0, '0},
        '{1'b0, CFG_LEFT_PIN, 6'd0,
          '{OP_SAMPLE, MODE_STOPPED, 16'd0, 6'd63, 16'h1234, 32'd23},
          1'b0, '0}
    };

    localparam int PHASES = 11;
    localparam int PHASE_ITEMS = 175;
    localparam int DRAIN_CYCLES = 40;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_t        in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_write_en = 1'b0;
    logic       cfg_index = CFG_LEFT_PIN;
    logic [5:0] cfg_data = '0;

    // Hand-typed expectation that travels with the transfer on the input side
    bit   want_typed = 1'b0;
    out_t want_fixed = '0;

    // Quiet tail: no gaps and no output stalls
    bit calm = 1'b0;
    int stall_left = 0;
    int mismatches = 0;

    out_t reports_due [$];

    // Predictor copy of the calibrator
    logic [5:0]  cal_left_pin = 6'd0;
    logic [5:0]  cal_right_pin = 6'd1;
    mode_t       cal_mode = MODE_STOPPED;
    logic [15:0] cal_window = '0;
    logic [31:0] cal_end = '0;
    logic [31:0] left_sum = '0;
    logic [31:0] left_n = '0;
    logic [31:0] right_sum = '0;
    logic [31:0] right_n = '0;
    logic [15:0] left_level = LEVEL_NEVER;
    logic [15:0] right_level = LEVEL_NEVER;

    light_sensor_window_mean_calibrator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Safety net: far beyond the slowest correct run
    initial
    begin
        #8000000;
        $display("light_sensor_window_mean_calibrator_core verification failed");
        $finish;
    end

    function automatic void clear_tallies();
        left_sum = '0;
        left_n = '0;
        right_sum = '0;
        right_n = '0;
    endfunction

    // Apply one accepted transfer to the predictor and return the output it causes
    function automatic out_t advance_calibration(in_t it);
        out_t        r;
        mode_t       nm;
        logic        closed;
        logic [31:0] quot;
        closed = 1'b0;
        if (it.op == OP_RESTART)
        begin
            nm = (it.new_mode == MODE_CODE_SPARE) ? MODE_FREERUN : mode_t'(it.new_mode);
            cal_mode = nm;
            cal_window = (nm == MODE_STOPPED) ? 16'd0 : it.window_length;
            cal_end = it.time_now + {16'd0, cal_window};
            clear_tallies();
        end
        else if (cal_mode != MODE_STOPPED)
        begin
            if (it.time_now >= cal_end)
            begin
                closed = 1'b1;
                // An empty side keeps its old threshold
                if (left_n != 0)
                begin
                    quot = left_sum / left_n;
                    left_level = quot[15:0];
                end
                if (right_n != 0)
                begin
                    quot = right_sum / right_n;
                    right_level = quot[15:0];
                end
                clear_tallies();
                if (cal_mode == MODE_ONESHOT)
                    cal_mode = MODE_STOPPED;
                else
                    cal_end = cal_end + {16'd0, cal_window};
            end
            if (cal_mode != MODE_STOPPED)
            begin
                // Left has priority when both pins match
                if (it.source_pin == cal_left_pin)
                begin
                    left_sum = left_sum + {16'd0, it.sample_value};
                    left_n = left_n + 32'd1;
                end
                else if (it.source_pin == cal_right_pin)
                begin
                    right_sum = right_sum + {16'd0, it.sample_value};
                    right_n = right_n + 32'd1;
                end
            end
        end
        r.left_threshold = left_level;
        r.right_threshold = right_level;
        r.calibrating = (cal_mode != MODE_STOPPED);
        r.window_closed = closed;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Output stall: random bursts of random length, none in the quiet tail
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end
        else
            out_stall <= 1'b0;
    end

    // Watch both channels. Values read here are the ones present before the
    // edge, since every driver updates with nonblocking assignments.
    always @(posedge clk)
    begin : watch
        out_t due;
        out_t predicted;
        if (rst_n)
        begin
            // Check the oldest outstanding report first
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t: unexpected output transfer, expected none, actual %h",
                             $time, out_data);
                    mismatches++;
                end
                else
                begin
                    due = reports_due.pop_front();
                    compare_field("left_threshold", due.left_threshold,
                                  out_data.left_threshold);
                    compare_field("right_threshold", due.right_threshold,
                                  out_data.right_threshold);
                    compare_field("calibrating", due.calibrating, out_data.calibrating);
                    compare_field("window_closed", due.window_closed,
                                  out_data.window_closed);
                end
            end
            // Advance the predictor on every accepted input transfer; a hand-typed
            // value takes the place of the prediction for its row
            if (in_valid && !in_stall)
            begin
                predicted = advance_calibration(in_data);
                reports_due.push_back(want_typed ? want_fixed : predicted);
            end
        end
    end

    // Present one transfer and hold it until taken; then maybe open a gap
    task automatic offer(input in_t item, input bit typed, input out_t want);
        in_valid <= 1'b1;
        in_data <= item;
        want_typed <= typed;
        want_fixed <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every outstanding report has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    // Write one pin register while the block is idle
    task automatic set_pin(input logic sel, input logic [5:0] pin);
        cfg_write_en <= 1'b1;
        cfg_index <= sel;
        cfg_data <= pin;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (sel == CFG_LEFT_PIN)
            cal_left_pin = pin;
        else
            cal_right_pin = pin;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        in_t         item;
        logic [31:0] tick_now;
        logic [5:0]  lp;
        logic [5:0]  rp;
        int          roll;
        int          ph;
        int          n;
        int          k;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan: reset state, extremes, every special case
        for (k = 0; k < PLAN_ROWS; k++)
        begin
            if (PLAN[k].is_cfg)
            begin
                settle();
                set_pin(PLAN[k].cfg_sel, PLAN[k].cfg_pin);
            end
            else
                offer(PLAN[k].item, PLAN[k].typed, PLAN[k].want);
        end

        // Random phases, each with its own pin setting
        tick_now = $urandom;
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            calm = (ph == PHASES - 1);
            case (ph)
                0:
                begin
                    lp = 6'd0;
                    rp = 6'd63;
                end
                1:
                begin
                    lp = 6'd63;
                    rp = 6'd0;
                end
                2:
                begin
                    lp = 6'($urandom_range(0, 63));
                    rp = lp;
                end
                default:
                begin
                    lp = 6'($urandom_range(0, 63));
                    rp = 6'($urandom_range(0, 63));
                end
            endcase
            set_pin(CFG_LEFT_PIN, lp);
            set_pin(CFG_RIGHT_PIN, rp);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Fields unused by the operation still toggle
                item = '0;
                item.new_mode = 2'($urandom);
                item.window_length = 16'($urandom);
                item.source_pin = 6'($urandom);
                item.sample_value = 16'($urandom);

                roll = $urandom_range(0, 99);
                if (roll < 6)
                begin
                    item.op = OP_RESTART;
                    roll = $urandom_range(0, 99);
                    if (roll < 10)
                        item.new_mode = MODE_STOPPED;
                    else if (roll < 40)
                        item.new_mode = MODE_ONESHOT;
                    else if (roll < 92)
                        item.new_mode = MODE_FREERUN;
                    else
                        item.new_mode = MODE_CODE_SPARE;
                    // Mostly short windows so that many close
                    if ($urandom_range(0, 9) != 0)
                        item.window_length = 16'($urandom_range(0, 120));
                end
                else
                begin
                    item.op = OP_SAMPLE;
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        item.source_pin = cal_left_pin;
                    else if (roll < 80)
                        item.source_pin = cal_right_pin;
                    roll = $urandom_range(0, 19);
                    if (roll == 0)
                        item.sample_value = 16'h0000;
                    else if (roll == 1)
                        item.sample_value = 16'hffff;
                end

                // Timer mostly creeps forward; now and then it jumps anywhere
                if ($urandom_range(0, 19) == 0)
                    tick_now = $urandom;
                else
                    tick_now = tick_now + $urandom_range(0, 12);
                item.time_now = tick_now;

                offer(item, 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("light_sensor_window_mean_calibrator_core verification clean");
        else
            $display("light_sensor_window_mean_calibrator_core verification failed");
        $finish;
    end

endmodule
